// File: rtl/core/ssa_pkg.sv
// Shared constants, types and a helper function of the slab allocator.
package ssa_pkg;

   // Arena geometry.
   localparam int ARENA_GRANULES = 4096;
   localparam int SIZE_CLASSES   = 64;
   localparam int GRANULE_BYTES  = 16;

   // Derived widths.
   localparam int GRAN_W     = $clog2(ARENA_GRANULES);      // header index
   localparam int PTR_W      = GRAN_W + 1;                  // index or null marker
   localparam int CLASS_W    = $clog2(SIZE_CLASSES);
   localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
   localparam int MAX_BYTES  = SIZE_CLASSES * GRANULE_BYTES;
   localparam int BYTES_W    = 11;
   localparam int ADDR_W     = 16;
   localparam int LIMIT_W    = 13;
   localparam int STATUS_W   = 2;

   localparam logic [PTR_W-1:0] NULL_MARK = PTR_W'(ARENA_GRANULES);

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_OOM     = 2'd1,
      ST_SIZE    = 2'd2,
      ST_BADFREE = 2'd3
   } ssa_status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_HEAD,
      S_LINK,
      S_BLOCK,
      S_FHEAD,
      S_RESP
   } ssa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           clear;
      logic           take_req;
      logic           rd_head;
      logic           rd_block;
      logic           rd_link;
      logic           pop;
      logic           carve;
      logic           push;
      logic           set_res;
      ssa_status_type res_status;
      logic           send;
   } ssa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic bad_size;
      logic bad_addr;
      logic head_empty;
      logic no_room;
      logic flag_set;
      logic out_free;
   } ssa_sts_type;

   // Byte offset of the data area that follows header granule hdr.
   function automatic logic [ADDR_W-1:0] data_addr(input logic [GRAN_W-1:0] hdr);
      logic [GRAN_W-1:0] hp1;
      hp1 = hdr + GRAN_W'(1);
      return ADDR_W'({hp1, {GRAN_SHIFT{1'b0}}});
   endfunction

endpackage

// File: rtl/core/ssa_channels.sv
// Request and response channel interfaces of the slab allocator.
interface ssa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [ssa_pkg::BYTES_W-1:0]   request_bytes;
   logic [ssa_pkg::ADDR_W-1:0]    block_address;

   modport source (output valid, output operation, output request_bytes,
                   output block_address, input ready);
   modport sink   (input valid, input operation, input request_bytes,
                   input block_address, output ready);
endinterface

interface ssa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssa_pkg::ADDR_W-1:0]    granted_address;
   logic [ssa_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output granted_address, output status, input ready);
   modport sink   (input valid, input granted_address, input status, output ready);
endinterface

// File: rtl/core/ssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/ssa_ctrl.sv
// Controller state machine sequencing the allocator's memory accesses.
module ssa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ssa_pkg::ssa_sts_type sts,
   output ssa_pkg::ssa_cmd_type cmd
);

   ssa_pkg::ssa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssa_pkg::S_CLEAR: begin
            if (sts.clear_last) state_in = ssa_pkg::S_IDLE;
         end
         ssa_pkg::S_IDLE: begin
            if (req_valid) state_in = ssa_pkg::S_DECODE;
         end
         ssa_pkg::S_DECODE: begin
            if (sts.is_free) begin
               state_in = sts.bad_addr ? ssa_pkg::S_RESP : ssa_pkg::S_BLOCK;
            end else begin
               state_in = sts.bad_size ? ssa_pkg::S_RESP : ssa_pkg::S_HEAD;
            end
         end
         ssa_pkg::S_HEAD: begin
            state_in = sts.head_empty ? ssa_pkg::S_RESP : ssa_pkg::S_LINK;
         end
         ssa_pkg::S_LINK: begin
            state_in = ssa_pkg::S_RESP;
         end
         ssa_pkg::S_BLOCK: begin
            state_in = sts.flag_set ? ssa_pkg::S_FHEAD : ssa_pkg::S_RESP;
         end
         ssa_pkg::S_FHEAD: begin
            state_in = ssa_pkg::S_RESP;
         end
         ssa_pkg::S_RESP: begin
            if (sts.out_free) state_in = ssa_pkg::S_IDLE;
         end
         default: begin
            state_in = ssa_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_status = ssa_pkg::ST_OK;
      req_ready      = 1'b0;
      case (state_ff)
         ssa_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ssa_pkg::S_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
         end
         ssa_pkg::S_DECODE: begin
            if (sts.is_free) begin
               if (sts.bad_addr) begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ssa_pkg::ST_BADFREE;
               end else begin
                  cmd.rd_block = 1'b1;
               end
            end else if (sts.bad_size) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ssa_pkg::ST_SIZE;
            end else begin
               cmd.rd_head = 1'b1;
            end
         end
         ssa_pkg::S_HEAD: begin
            if (!sts.head_empty) begin
               cmd.rd_link = 1'b1;
            end else if (sts.no_room) begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ssa_pkg::ST_OOM;
            end else begin
               cmd.carve   = 1'b1;
               cmd.set_res = 1'b1;
            end
         end
         ssa_pkg::S_LINK: begin
            cmd.pop     = 1'b1;
            cmd.set_res = 1'b1;
         end
         ssa_pkg::S_BLOCK: begin
            if (sts.flag_set) begin
               cmd.rd_head = 1'b1;
            end else begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ssa_pkg::ST_BADFREE;
            end
         end
         ssa_pkg::S_FHEAD: begin
            cmd.push    = 1'b1;
            cmd.set_res = 1'b1;
         end
         ssa_pkg::S_RESP: begin
            cmd.send = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/ssa_datapath.sv
// Datapath: request decode, bump pointer, free-list memories and result register.
module ssa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [ssa_pkg::LIMIT_W-1:0]    csr_write_data,
   input  logic                           req_operation,
   input  logic [ssa_pkg::BYTES_W-1:0]    req_request_bytes,
   input  logic [ssa_pkg::ADDR_W-1:0]     req_block_address,
   input  ssa_pkg::ssa_cmd_type           cmd,
   output ssa_pkg::ssa_sts_type           sts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ssa_pkg::ADDR_W-1:0]     rsp_granted_address,
   output logic [ssa_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int GW = ssa_pkg::GRAN_W;
   localparam int PW = ssa_pkg::PTR_W;
   localparam int CW = ssa_pkg::CLASS_W;
   localparam int AW = ssa_pkg::ADDR_W;
   localparam int BW = ssa_pkg::BYTES_W;

   // Control registers.
   logic [ssa_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [PW-1:0]               bump_ff, bump_in;
   logic [GW-1:0]               clr_idx_ff, clr_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic                        op_ff;
   logic [BW-1:0]               bytes_ff;
   logic [AW-1:0]               addr_ff;
   logic [GW-1:0]               hdr_ff;
   logic [CW-1:0]               fcls_ff;
   ssa_pkg::ssa_status_type     res_status_ff;
   logic [AW-1:0]               res_addr_ff, res_addr_in;
   logic [AW-1:0]               rsp_addr_ff;
   logic [ssa_pkg::STATUS_W-1:0] rsp_status_ff;

   // Memory read data.
   logic [PW-1:0] head_rdata, link_rdata;
   logic [CW-1:0] class_rdata;
   logic          flag_rdata;

   // Decode of the latched request.
   logic [BW:0]                    bytes_up;
   logic [BW-ssa_pkg::GRAN_SHIFT:0] gran_cnt;
   logic [CW-1:0]                  alloc_cls;
   logic [PW-1:0]                  need;
   logic [GW-1:0]                  free_gran;
   logic [GW-1:0]                  free_hdr;
   logic [PW-1:0]                  eff_limit;

   assign bytes_up  = {1'b0, bytes_ff} + (BW+1)'(ssa_pkg::GRANULE_BYTES - 1);
   assign gran_cnt  = (BW-ssa_pkg::GRAN_SHIFT+1)'(bytes_up >> ssa_pkg::GRAN_SHIFT);
   assign alloc_cls = CW'(gran_cnt - (BW-ssa_pkg::GRAN_SHIFT+1)'(1));
   assign need      = PW'(gran_cnt) + PW'(1);
   assign free_gran = addr_ff[AW-1 -: GW];
   assign free_hdr  = free_gran - GW'(1);
   assign eff_limit = (limit_ff > ssa_pkg::LIMIT_W'(ssa_pkg::ARENA_GRANULES))
                      ? PW'(ssa_pkg::ARENA_GRANULES) : PW'(limit_ff);

   always_comb begin
      sts            = '0;
      sts.clear_last = (clr_idx_ff == GW'(ssa_pkg::ARENA_GRANULES - 1));
      sts.is_free    = (op_ff == ssa_pkg::OP_FREE);
      sts.bad_size   = (bytes_ff == '0) || (bytes_ff > BW'(ssa_pkg::MAX_BYTES));
      sts.bad_addr   = (addr_ff[ssa_pkg::GRAN_SHIFT-1:0] != '0) || (free_gran == '0)
                       || ({1'b0, free_hdr} >= bump_ff);
      sts.head_empty = head_rdata[PW-1];
      sts.no_room    = (bump_ff >= eff_limit) || ((eff_limit - bump_ff) < need);
      sts.flag_set   = flag_rdata;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // Control register updates.
   always_comb begin
      limit_in     = csr_write_enable ? csr_write_data : limit_ff;
      bump_in      = cmd.carve ? bump_ff + need : bump_ff;
      clr_idx_in   = cmd.clear ? clr_idx_ff + GW'(1) : clr_idx_ff;
      rsp_valid_in = cmd.send ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ssa_pkg::LIMIT_W'(ssa_pkg::ARENA_GRANULES);
         bump_ff      <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         bump_ff      <= bump_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      if (cmd.pop) begin
         res_addr_in = ssa_pkg::data_addr(hdr_ff);
      end else if (cmd.carve) begin
         res_addr_in = ssa_pkg::data_addr(bump_ff[GW-1:0]);
      end else begin
         res_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff    <= req_operation;
         bytes_ff <= req_request_bytes;
         addr_ff  <= req_block_address;
      end
      if (cmd.rd_link) begin
         hdr_ff <= head_rdata[GW-1:0];
      end
      if (cmd.rd_head && op_ff == ssa_pkg::OP_FREE) begin
         fcls_ff <= class_rdata;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_addr_ff   <= res_addr_in;
      end
      if (cmd.send) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // Class head table: cleared to the null marker during the reset sweep.
   logic          head_we;
   logic [CW-1:0] head_waddr, head_raddr;
   logic [PW-1:0] head_wdata;

   always_comb begin
      head_we    = 1'b0;
      head_waddr = alloc_cls;
      head_wdata = link_rdata;
      if (cmd.clear) begin
         head_we    = (clr_idx_ff[GW-1:CW] == '0);
         head_waddr = clr_idx_ff[CW-1:0];
         head_wdata = ssa_pkg::NULL_MARK;
      end else if (cmd.pop) begin
         head_we = 1'b1;
      end else if (cmd.push) begin
         head_we    = 1'b1;
         head_waddr = fcls_ff;
         head_wdata = {1'b0, free_hdr};
      end
   end

   assign head_raddr = (op_ff == ssa_pkg::OP_FREE) ? class_rdata : alloc_cls;

   ssa_ram #(.WIDTH(PW), .DEPTH(ssa_pkg::SIZE_CLASSES)) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .waddr (head_waddr),
      .wdata (head_wdata),
      .re    (cmd.rd_head),
      .raddr (head_raddr),
      .rdata (head_rdata)
   );

   // Free-list links.
   ssa_ram #(.WIDTH(PW), .DEPTH(ssa_pkg::ARENA_GRANULES)) u_link_ram (
      .clock (clock),
      .we    (cmd.push),
      .waddr (free_hdr),
      .wdata (head_rdata),
      .re    (cmd.rd_link),
      .raddr (head_rdata[GW-1:0]),
      .rdata (link_rdata)
   );

   // Size class recorded per carved block.
   ssa_ram #(.WIDTH(CW), .DEPTH(ssa_pkg::ARENA_GRANULES)) u_class_ram (
      .clock (clock),
      .we    (cmd.carve),
      .waddr (bump_ff[GW-1:0]),
      .wdata (alloc_cls),
      .re    (cmd.rd_block),
      .raddr (free_hdr),
      .rdata (class_rdata)
   );

   // Allocated flags: cleared by the reset sweep.
   logic          flag_we, flag_wdata;
   logic [GW-1:0] flag_waddr;

   always_comb begin
      flag_we    = cmd.clear | cmd.pop | cmd.carve | cmd.push;
      flag_waddr = clr_idx_ff;
      flag_wdata = 1'b0;
      if (cmd.pop) begin
         flag_waddr = hdr_ff;
         flag_wdata = 1'b1;
      end else if (cmd.carve) begin
         flag_waddr = bump_ff[GW-1:0];
         flag_wdata = 1'b1;
      end else if (cmd.push) begin
         flag_waddr = free_hdr;
      end
   end

   ssa_ram #(.WIDTH(1), .DEPTH(ssa_pkg::ARENA_GRANULES)) u_flag_ram (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .re    (cmd.rd_block),
      .raddr (free_hdr),
      .rdata (flag_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   // The bump pointer never runs past the arena.
   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= PW'(ssa_pkg::ARENA_GRANULES))
      else $error("bump pointer past arena end");

   // A carve advances the bump pointer by header plus data granules.
   a_carve_step: assert property (@(posedge clock) disable iff (reset)
      cmd.carve |=> bump_ff == $past(bump_ff) + $past(need))
      else $error("bump pointer step mismatch");

   // A pop only follows a non-empty class head.
   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !head_rdata[PW-1])
      else $error("pop from empty free list");

   // Only one state-changing memory operation per cycle.
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.pop, cmd.carve, cmd.push}))
      else $error("conflicting memory updates");

endmodule

// File: rtl/core/segregated_slab_allocator.sv
// Top level of the segregated slab allocator: controller, datapath and channels.
//
// The block serves allocate and free requests over a 64 KiB arena of 16-byte
// granules. An allocate rounds the size up to whole granules, pops the free
// list of that size class, or else carves a header granule plus the block from
// the bump pointer below heap_limit, and returns the data address past the
// header. A free pushes the block back on the list of the class recorded when
// it was carved. Each accepted item gives exactly one result item. An item
// reaches the response register through a chain of registered memory reads
// (class head then link on a reused allocate, flag and class then head on a
// free); the block then returns to idle before the next request is taken.
// Size and address errors settle in the decode state, out-of-memory after
// the class head read, a free of an unallocated block after the flag read.
// A finished result waits in the response register while the next request
// is taken; a second result waits until that register is free. After reset
// a clearing pass empties the class heads and the allocated flags; no request
// is taken until it ends, while writes of heap_limit are taken at any time.
module segregated_slab_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [ssa_pkg::LIMIT_W-1:0]  csr_write_data,
   ssa_req_if.sink                      req_chan,
   ssa_rsp_if.source                    rsp_chan
);

   // Command and status between the controller and the datapath.
   ssa_pkg::ssa_cmd_type cmd;
   ssa_pkg::ssa_sts_type sts;

   // The controller owns sequencing and the request handshake.
   ssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the heap registers, memories and the response register.
   ssa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_operation       (req_chan.operation),
      .req_request_bytes   (req_chan.request_bytes),
      .req_block_address   (req_chan.block_address),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_granted_address (rsp_chan.granted_address),
      .rsp_status          (rsp_chan.status)
   );

endmodule
